/* hw/rtl/lppd_pkg.sv */
// ---------------------------------------------------------------------------
// lppd_pkg - shared types and constants
// Result record, configuration record and character codes of the deframer.
// ---------------------------------------------------------------------------
package lppd_pkg;

  localparam int MAX_DIGITS_DEF  = 5;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] LEN_LIMIT_RST = 16'hFFFE;
  localparam int          CFG_AW        = 3;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_EARLY_END = 3'd0,
    ERR_TYPE_ZERO = 3'd1,
    ERR_NO_SPACE  = 3'd2,
    ERR_NO_DIGITS = 3'd3,
    ERR_NON_DIGIT = 3'd4,
    ERR_TOO_LONG  = 3'd5,
    ERR_OVER_MAX  = 3'd6,
    ERR_NO_CLOSE  = 3'd7
  } err_t;

  // register index is paddr[2]
  typedef enum logic {
    REG_MAX_LENGTH = 1'b0,
    REG_END_OK     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ptype;
    logic [7:0]  data;
    logic [15:0] len;
    err_t        code;
  } result_t;

  typedef struct packed {
    logic [15:0] max_length;
    logic        end_ok;
  } cfg_t;

endpackage

/* hw/rtl/lppd_parser.sv */
// ---------------------------------------------------------------------------
// lppd_parser - front end
// Classifies each accepted beat, walks the framing state and forms a result.
// ---------------------------------------------------------------------------
module lppd_parser #(
  parameter int MAX_DIGITS = lppd_pkg::MAX_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       byte_value,
  input  logic             stream_end,
  input  lppd_pkg::cfg_t   cfg,
  output logic             emit,
  output lppd_pkg::result_t res
);
  import lppd_pkg::*;

  localparam int DCW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [4:0] {
    PH_TYPE    = 5'b00001,
    PH_SPACE   = 5'b00010,
    PH_DIGITS  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CLOSE   = 5'b10000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       cur_type_r, cur_type_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic [DCW-1:0]   dcnt_r, dcnt_nxt;
  logic [15:0]      rem_r, rem_nxt;

  logic             fail;
  err_t             fail_code;
  logic             clear;
  logic             is_digit;
  logic [19:0]      acc_next;
  logic [15:0]      rem_dec;

  assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
  // acc*10 + digit, wide enough for 65535*10+9
  assign acc_next = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                  + {12'h000, byte_value - CH_ZERO};
  assign rem_dec  = (rem_r != 16'd0) ? rem_r - 16'd1 : rem_r;

  always_comb begin
    phase_nxt    = phase_r;
    cur_type_nxt = cur_type_r;
    acc_nxt      = acc_r;
    dcnt_nxt     = dcnt_r;
    rem_nxt      = rem_r;
    emit         = 1'b0;
    res          = '0;
    fail         = 1'b0;
    fail_code    = ERR_EARLY_END;
    clear        = 1'b0;

    if (fire) begin
      if (stream_end) begin
        if (phase_r == PH_TYPE && cfg.end_ok) begin
          emit     = 1'b1;
          res.kind = KIND_END;
          clear    = 1'b1;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_EARLY_END;
        end
      end else begin
        case (phase_r)
          PH_TYPE: begin
            if (byte_value == 8'd0) begin
              fail      = 1'b1;
              fail_code = ERR_TYPE_ZERO;
            end else begin
              cur_type_nxt = byte_value;
              acc_nxt      = '0;
              dcnt_nxt     = '0;
              rem_nxt      = '0;
              phase_nxt    = PH_SPACE;
            end
          end
          PH_SPACE: begin
            if (byte_value != CH_SPACE) begin
              fail      = 1'b1;
              fail_code = ERR_NO_SPACE;
            end else begin
              phase_nxt = PH_DIGITS;
            end
          end
          PH_DIGITS: begin
            if (byte_value == CH_NEWLINE) begin
              if (dcnt_r == '0) begin
                fail      = 1'b1;
                fail_code = ERR_NO_DIGITS;
              end else begin
                rem_nxt   = acc_r;
                phase_nxt = (acc_r == 16'd0) ? PH_CLOSE : PH_PAYLOAD;
              end
            end else if (!is_digit) begin
              fail      = 1'b1;
              fail_code = ERR_NON_DIGIT;
            end else if (dcnt_r >= DCW'(MAX_DIGITS)) begin
              fail      = 1'b1;
              fail_code = ERR_TOO_LONG;
            end else if (acc_next > {4'h0, cfg.max_length}) begin
              fail      = 1'b1;
              fail_code = ERR_OVER_MAX;
            end else begin
              acc_nxt  = acc_next[15:0];
              dcnt_nxt = dcnt_r + DCW'(1);
            end
          end
          PH_PAYLOAD: begin
            rem_nxt = rem_dec;
            if (rem_dec == 16'd0) begin
              phase_nxt = PH_CLOSE;
            end
            emit      = 1'b1;
            res.kind  = KIND_DATA;
            res.ptype = cur_type_r;
            res.data  = byte_value;
          end
          PH_CLOSE: begin
            if (byte_value != CH_NEWLINE) begin
              fail      = 1'b1;
              fail_code = ERR_NO_CLOSE;
            end else begin
              emit      = 1'b1;
              res.kind  = KIND_DONE;
              res.ptype = cur_type_r;
              res.len   = acc_r;
              clear     = 1'b1;
            end
          end
          default: begin
            clear = 1'b1;
          end
        endcase
      end

      if (fail) begin
        emit      = 1'b1;
        res       = '0;
        res.kind  = KIND_ERROR;
        res.ptype = cur_type_r;
        res.code  = fail_code;
        clear     = 1'b1;
      end

      if (clear) begin
        phase_nxt    = PH_TYPE;
        cur_type_nxt = '0;
        acc_nxt      = '0;
        dcnt_nxt     = '0;
        rem_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TYPE;
      cur_type_r <= '0;
      acc_r      <= '0;
      dcnt_r     <= '0;
      rem_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      cur_type_r <= cur_type_nxt;
      acc_r      <= acc_nxt;
      dcnt_r     <= dcnt_nxt;
      rem_r      <= rem_nxt;
    end
  end

  // payload phase always has bytes outstanding
  a_payload_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> rem_r != 16'd0)
    else $error("payload phase with nothing left");

  // type register is cleared between packets
  a_idle_type: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TYPE |-> cur_type_r == 8'd0)
    else $error("stale type while waiting for type byte");

  // remaining count never exceeds the declared length
  a_rem_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> rem_r <= acc_r)
    else $error("remaining count above length");

endmodule

/* hw/rtl/lppd_queue.sv */
// ---------------------------------------------------------------------------
// lppd_queue - result queue
// Small FIFO between parser and output stage; read data is registered.
// ---------------------------------------------------------------------------
module lppd_queue #(
  parameter int DEPTH = lppd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lppd_pkg::result_t push_data,
  input  logic              pop,
  output lppd_pkg::result_t rd_data,
  output logic              full,
  output logic              empty
);
  import lppd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t          mem [DEPTH];
  result_t          rd_data_r;
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = rd_data_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

/* hw/rtl/lppd_out.sv */
// ---------------------------------------------------------------------------
// lppd_out - back end
// Output stage: pulls results from the queue and holds them until taken.
// ---------------------------------------------------------------------------
module lppd_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  lppd_pkg::result_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_result_kind,
  output logic [7:0]        out_packet_type,
  output logic [7:0]        out_data_byte,
  output logic [15:0]       out_packet_length,
  output logic [2:0]        out_error_code
);
  import lppd_pkg::*;

  logic valid_r, valid_nxt;

  // refill whenever the held beat is absent or leaving
  assign q_pop = !q_empty && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_result_kind   = q_data.kind;
  assign out_packet_type   = q_data.ptype;
  assign out_data_byte     = q_data.data;
  assign out_packet_length = q_data.len;
  assign out_error_code    = q_data.code;

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(q_data))
    else $error("held beat changed under stall");

  a_pop_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !valid_r || out_ready)
    else $error("pop would overwrite a held beat");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r && !q_empty |=> valid_r)
    else $error("output stage failed to fill");

endmodule

/* hw/rtl/length_prefixed_packet_deframer.sv */
// ---------------------------------------------------------------------------
// length_prefixed_packet_deframer - top level
// Parses "<type> <len>\n<payload>\n" frames out of a byte stream.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_*): one beat is one stream byte, or an end-of-stream
//    marker when in_stream_end is high (in_byte_value is then ignored).
//  - Output channel (out_*): zero or one result beat per input beat:
//    a payload byte tagged with its type, a packet-done beat with type and
//    length, an error beat with a code, or a clean end of stream.
//  - Config (APB): max_length at 0x0, end_ok_at_boundary at 0x4. Decode
//    uses paddr[2] only. Write only while the block is idle.
//  - Throughput: one input beat per cycle while the queue has room. Each
//    byte needs just one state update in the parser, and the queue and
//    output stage each move one beat per cycle while out_ready is high.
//  - Path: a result is written into the queue by the parser and then read
//    out into the output register (parser -> queue write, queue read).
//  - Stall: while out_ready is low results collect in a QUEUE_DEPTH-entry
//    queue; in_ready drops only once that queue is full.
//  - Reset (rst_n, synchronous, active low): parser waits for a type byte,
//    queue and output stage empty, registers back to max_length 65534 and
//    end_ok_at_boundary 1. No clearing pass is needed.
// ---------------------------------------------------------------------------
module length_prefixed_packet_deframer #(
  parameter int MAX_DIGITS  = lppd_pkg::MAX_DIGITS_DEF,
  parameter int QUEUE_DEPTH = lppd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte_value,
  input  logic                        in_stream_end,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_result_kind,
  output logic [7:0]                  out_packet_type,
  output logic [7:0]                  out_data_byte,
  output logic [15:0]                 out_packet_length,
  output logic [2:0]                  out_error_code,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lppd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lppd_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  logic     in_fire;
  logic     emit;
  result_t  res;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  result_t  q_data;

  // --- configuration registers ---
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_MAX_LENGTH: cfg_nxt.max_length = pwdata[15:0];
        REG_END_OK:     cfg_nxt.end_ok     = pwdata[0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MAX_LENGTH: prdata = {16'h0000, cfg_r.max_length};
      REG_END_OK:     prdata = {31'h0, cfg_r.end_ok};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_length <= LEN_LIMIT_RST;
      cfg_r.end_ok     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // --- front: accept and parse ---
  // a beat is taken whenever the queue has room, whether it yields a result
  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  lppd_parser #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .byte_value (in_byte_value),
    .stream_end (in_stream_end),
    .cfg        (cfg_r),
    .emit       (emit),
    .res        (res)
  );

  // --- queue between front and back ---
  lppd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (res),
    .pop       (q_pop),
    .rd_data   (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // --- back: output register ---
  lppd_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_packet_type   (out_packet_type),
    .out_data_byte     (out_data_byte),
    .out_packet_length (out_packet_length),
    .out_error_code    (out_error_code)
  );

  // a result is formed only from an input beat that was taken
  a_push_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> in_fire)
    else $error("result formed without an input beat");

  // end of stream inside a packet or with end not allowed is an error beat
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    emit && in_stream_end |-> res.kind == KIND_END || res.kind == KIND_ERROR)
    else $error("bad result for end of stream");

  // config only moves on an APB write
  a_cfg_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |=> $stable(cfg_r))
    else $error("config changed without a write");

endmodule
